FILE: src/assert_macros.svh
// Assertion helpers for the top RTL file of the vertex normal block.
// Both macros sample on the rising edge of clock and are quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define VNA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define VNA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types, codes and defaults of the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

   localparam int IDX_BITS       = 10;
   localparam int NORM_BITS      = 16;
   localparam int STEP_BITS      = 5;

   localparam int DEF_MAX_VERTICES  = 1024;
   localparam int DEF_MAX_TRIANGLES = 2048;
   localparam int DEF_COORD_BITS    = 16;

   localparam int MUL_STEPS  = 6;
   localparam int ROOT_STEPS = 32;
   localparam int DIV_STEPS  = 16;
   localparam int COMPONENTS = 3;

   localparam logic [1:0] CMD_CLEAR    = 2'd0;
   localparam logic [1:0] CMD_VERTEX   = 2'd1;
   localparam logic [1:0] CMD_TRIANGLE = 2'd2;
   localparam logic [1:0] CMD_COMPUTE  = 2'd3;

   localparam logic [1:0] RS_PRESET   = 2'd0;
   localparam logic [1:0] RS_COMPUTED = 2'd1;
   localparam logic [1:0] RS_NO_TRI   = 2'd2;
   localparam logic [1:0] RS_DEGEN    = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE, ST_NCHK, ST_TREAD, ST_TCHK, ST_P1, ST_P2, ST_PCAP, ST_DIFF,
      ST_MUL, ST_CROSS, ST_TNEXT, ST_FIN, ST_MAX, ST_NORM, ST_SQ, ST_RINIT,
      ST_ROOT, ST_DINIT, ST_DIV, ST_DSTORE, ST_OUT
   } vna_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CLEAR, OP_VWRITE, OP_APPEND, OP_START, OP_TREAD, OP_PREAD0,
      OP_PREAD1, OP_PREAD2, OP_PCAP, OP_DIFF, OP_MUL, OP_CROSS, OP_TNEXT,
      OP_ABS, OP_MAX, OP_NORM, OP_SQ, OP_RINIT, OP_ROOT, OP_DINIT, OP_DIV,
      OP_DSTORE, OP_EMIT
   } vna_op_type;

   typedef struct packed {
      vna_op_type           op;
      logic [STEP_BITS-1:0] step;
      logic [1:0]           comp;
      logic [1:0]           rstat;
   } vna_cmd_type;

   typedef struct packed {
      logic nz_normal;
      logic t_end;
      logic hit;
      logic no_uses;
      logic acc_zero;
      logic norm_hi;
      logic norm_lo;
   } vna_stat_type;

endpackage

FILE: src/vna_ctrl.sv
// ----------------------------------------------------------------------------
// vna_ctrl
// Sequencer that steps the datapath through load, walk and normalize phases.
// ----------------------------------------------------------------------------
module vna_ctrl
   import vna_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [1:0]   req_cmd,
   input  vna_stat_type stat,
   output vna_cmd_type  cmd,
   output logic         busy
);

   vna_state_type        state_ff, state_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic [1:0]           comp_ff, comp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         comp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         comp_ff  <= comp_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      comp_in   = comp_ff;
      cmd.op    = OP_NONE;
      cmd.step  = cnt_ff;
      cmd.comp  = comp_ff;
      cmd.rstat = RS_PRESET;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_cmd)
                  CMD_CLEAR:    cmd.op = OP_CLEAR;
                  CMD_VERTEX:   cmd.op = OP_VWRITE;
                  CMD_TRIANGLE: cmd.op = OP_APPEND;
                  CMD_COMPUTE: begin
                     cmd.op   = OP_START;
                     state_in = ST_NCHK;
                  end
               endcase
            end
         end
         ST_NCHK: begin
            if (stat.nz_normal) begin
               cmd.op    = OP_EMIT;
               cmd.rstat = RS_PRESET;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_TREAD;
            end
         end
         ST_TREAD: begin
            if (stat.t_end) begin
               state_in = ST_FIN;
            end else begin
               cmd.op   = OP_TREAD;
               state_in = ST_TCHK;
            end
         end
         ST_TCHK: begin
            if (stat.hit) begin
               cmd.op   = OP_PREAD0;
               state_in = ST_P1;
            end else begin
               cmd.op   = OP_TNEXT;
               state_in = ST_TREAD;
            end
         end
         ST_P1: begin
            cmd.op   = OP_PREAD1;
            state_in = ST_P2;
         end
         ST_P2: begin
            cmd.op   = OP_PREAD2;
            state_in = ST_PCAP;
         end
         ST_PCAP: begin
            cmd.op   = OP_PCAP;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.op   = OP_DIFF;
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.op   = OP_MUL;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            cmd.op = OP_CROSS;
            if (cnt_ff == STEP_BITS'(MUL_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_TNEXT;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_TNEXT: begin
            cmd.op   = OP_TNEXT;
            state_in = ST_TREAD;
         end
         ST_FIN: begin
            if (stat.no_uses) begin
               cmd.op    = OP_EMIT;
               cmd.rstat = RS_NO_TRI;
               state_in  = ST_IDLE;
            end else if (stat.acc_zero) begin
               cmd.op    = OP_EMIT;
               cmd.rstat = RS_DEGEN;
               state_in  = ST_IDLE;
            end else begin
               cmd.op   = OP_ABS;
               state_in = ST_MAX;
            end
         end
         ST_MAX: begin
            cmd.op   = OP_MAX;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            if (stat.norm_hi || stat.norm_lo) begin
               cmd.op = OP_NORM;
            end else begin
               cnt_in   = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            cmd.op = OP_SQ;
            if (cnt_ff == STEP_BITS'(COMPONENTS - 1)) begin
               cnt_in   = '0;
               state_in = ST_RINIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_RINIT: begin
            cmd.op   = OP_RINIT;
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.op = OP_ROOT;
            if (cnt_ff == STEP_BITS'(ROOT_STEPS - 1)) begin
               cnt_in   = '0;
               comp_in  = '0;
               state_in = ST_DINIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DINIT: begin
            cmd.op   = OP_DINIT;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = OP_DIV;
            if (cnt_ff == STEP_BITS'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_DSTORE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DSTORE: begin
            cmd.op = OP_DSTORE;
            if (comp_ff == 2'(COMPONENTS - 1)) begin
               comp_in  = '0;
               state_in = ST_OUT;
            end else begin
               comp_in  = comp_ff + 1'b1;
               state_in = ST_DINIT;
            end
         end
         ST_OUT: begin
            cmd.op    = OP_EMIT;
            cmd.rstat = RS_COMPUTED;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: src/vna_dpath.sv
// ----------------------------------------------------------------------------
// vna_dpath
// Mesh stores, cross product accumulator and unit length scaling unit.
// ----------------------------------------------------------------------------
module vna_dpath
   import vna_pkg::*;
#(
   parameter int MAX_VERTICES  = DEF_MAX_VERTICES,
   parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES,
   parameter int COORD_BITS    = DEF_COORD_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  vna_cmd_type                 cmd,
   output vna_stat_type                stat,
   input  logic [IDX_BITS-1:0]         req_vertex_index,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_pos_z,
   input  logic signed [NORM_BITS-1:0] req_preset_nx,
   input  logic signed [NORM_BITS-1:0] req_preset_ny,
   input  logic signed [NORM_BITS-1:0] req_preset_nz,
   input  logic [IDX_BITS-1:0]         req_corner_a,
   input  logic [IDX_BITS-1:0]         req_corner_b,
   input  logic [IDX_BITS-1:0]         req_corner_c,
   output logic                        rsp_valid,
   output logic [IDX_BITS-1:0]         rsp_result_vertex,
   output logic signed [NORM_BITS-1:0] rsp_normal_x,
   output logic signed [NORM_BITS-1:0] rsp_normal_y,
   output logic signed [NORM_BITS-1:0] rsp_normal_z,
   output logic [1:0]                  rsp_status
);

   localparam int VIDX   = $clog2(MAX_VERTICES);
   localparam int TIDX   = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
   localparam int TCNT   = $clog2(MAX_TRIANGLES + 1);
   localparam int POS_W  = 3 * COORD_BITS;
   localparam int NRM_W  = 3 * NORM_BITS;
   localparam int TRI_W  = 3 * VIDX;
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int WRAP_SHIFT = 20;
   localparam logic [31:0] MAXV32 = 32'(MAX_VERTICES);
   localparam logic [31:0] RECIP  = 32'((2 ** WRAP_SHIFT) / MAX_VERTICES);
   localparam logic signed [65:0] ACC_LIM = 66'sh4000_0000_0000_0000;

   // Index modulo the vertex count: reciprocal estimate plus one correction.
   function automatic logic [VIDX-1:0] wrap_idx(input logic [IDX_BITS-1:0] v);
      logic [31:0] q;
      logic [31:0] r;
      q = (32'(v) * RECIP) >> WRAP_SHIFT;
      r = 32'(v) - q * MAXV32;
      if (r >= MAXV32) r = r - MAXV32;
      return r[VIDX-1:0];
   endfunction

   function automatic logic signed [COORD_BITS-1:0] crd(input logic [POS_W-1:0] p,
                                                        input int k);
      return p[k*COORD_BITS +: COORD_BITS];
   endfunction

   logic [POS_W-1:0] pos_mem [MAX_VERTICES];
   logic [NRM_W-1:0] nrm_mem [MAX_VERTICES];
   logic [TRI_W-1:0] tri_mem [MAX_TRIANGLES];

   logic [VIDX-1:0]  vi_ff;
   logic [NRM_W-1:0] nrm_rd_ff;
   logic [TRI_W-1:0] tri_rd_ff;
   logic [POS_W-1:0] pos_rd_ff, p0_ff, p1_ff, p2_ff;
   logic [TCNT-1:0]  t_ff, tcount_ff;
   logic             uses_ff;
   logic signed [DIFF_W-1:0] a_ff [3];
   logic signed [DIFF_W-1:0] b_ff [3];
   logic signed [PROD_W-1:0] prod_ff, cr_ff;
   logic signed [63:0] acc_ff [3];
   logic [62:0]        u_ff [3];
   logic [62:0]        mx_ff;
   logic [63:0]        s_ff, rem_ff, root_ff, bit_ff;
   logic [45:0]        dnum_ff, dsr_ff;
   logic [NORM_BITS-1:0] q_ff;
   logic signed [NORM_BITS-1:0] res_ff [3];
   logic               rsp_valid_ff;
   logic [IDX_BITS-1:0] rsp_vertex_ff;
   logic [NORM_BITS-1:0] rsp_nx_ff, rsp_ny_ff, rsp_nz_ff;
   logic [1:0]         rsp_status_ff;

   logic [VIDX-1:0]  pos_addr;
   logic signed [DIFF_W-1:0] ma, mb;
   logic signed [PROD_W-1:0] prod_w;
   logic signed [63:0] acc_sel;
   logic signed [65:0] sum_w;
   logic signed [63:0] sat_w;
   logic [63:0]        abs_w [3];
   logic [29:0]        u_sq;
   logic [59:0]        sq_w;
   logic [63:0]        trial_w;
   logic [NRM_W-1:0]   emit_nrm;

   always_comb begin
      pos_addr = tri_rd_ff[0 +: VIDX];
      case (cmd.op)
         OP_PREAD1: pos_addr = tri_rd_ff[VIDX +: VIDX];
         OP_PREAD2: pos_addr = tri_rd_ff[2*VIDX +: VIDX];
         default:   pos_addr = tri_rd_ff[0 +: VIDX];
      endcase
   end

   // Operand pairs of the three cross product components, two per component.
   always_comb begin
      case (cmd.step)
         5'd0:    begin ma = a_ff[1]; mb = b_ff[2]; end
         5'd1:    begin ma = a_ff[2]; mb = b_ff[1]; end
         5'd2:    begin ma = a_ff[2]; mb = b_ff[0]; end
         5'd3:    begin ma = a_ff[0]; mb = b_ff[2]; end
         5'd4:    begin ma = a_ff[0]; mb = b_ff[1]; end
         default: begin ma = a_ff[1]; mb = b_ff[0]; end
      endcase
   end

   assign prod_w  = PROD_W'(ma) * PROD_W'(mb);
   assign acc_sel = acc_ff[cmd.step[2:1]];
   assign sum_w   = 66'(acc_sel) + 66'(cr_ff) - 66'(prod_ff);

   always_comb begin
      if (sum_w > ACC_LIM)       sat_w = 64'(ACC_LIM);
      else if (sum_w < -ACC_LIM) sat_w = 64'(-ACC_LIM);
      else                       sat_w = 64'(sum_w);
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         abs_w[k] = acc_ff[k][63] ? 64'(-acc_ff[k]) : 64'(acc_ff[k]);
      end
   end

   assign u_sq    = u_ff[cmd.step[1:0]][29:0];
   assign sq_w    = 60'(u_sq) * 60'(u_sq);
   assign trial_w = root_ff + bit_ff;

   always_comb begin
      case (cmd.rstat)
         RS_PRESET:   emit_nrm = nrm_rd_ff;
         RS_COMPUTED: emit_nrm = {res_ff[2], res_ff[1], res_ff[0]};
         default:     emit_nrm = '0;
      endcase
   end

   // Stores.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_VWRITE) begin
         pos_mem[wrap_idx(req_vertex_index)] <= {req_pos_z, req_pos_y, req_pos_x};
      end
      pos_rd_ff <= pos_mem[pos_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_VWRITE) begin
         nrm_mem[wrap_idx(req_vertex_index)] <=
            {req_preset_nz, req_preset_ny, req_preset_nx};
      end else if (cmd.op == OP_EMIT && cmd.rstat != RS_PRESET) begin
         nrm_mem[vi_ff] <= emit_nrm;
      end
      if (cmd.op == OP_START) begin
         nrm_rd_ff <= nrm_mem[wrap_idx(req_vertex_index)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_APPEND && tcount_ff < TCNT'(MAX_TRIANGLES)) begin
         tri_mem[tcount_ff[TIDX-1:0]] <=
            {wrap_idx(req_corner_c), wrap_idx(req_corner_b), wrap_idx(req_corner_a)};
      end
      if (cmd.op == OP_TREAD) begin
         tri_rd_ff <= tri_mem[t_ff[TIDX-1:0]];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd.op == OP_EMIT);
         if (cmd.op == OP_CLEAR) begin
            tcount_ff <= '0;
         end else if (cmd.op == OP_APPEND && tcount_ff < TCNT'(MAX_TRIANGLES)) begin
            tcount_ff <= tcount_ff + 1'b1;
         end
      end
   end

   // Arithmetic and walk registers.
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_START: begin
            vi_ff   <= wrap_idx(req_vertex_index);
            t_ff    <= '0;
            uses_ff <= 1'b0;
            for (int k = 0; k < 3; k++) acc_ff[k] <= '0;
         end
         OP_PREAD1: p0_ff <= pos_rd_ff;
         OP_PREAD2: p1_ff <= pos_rd_ff;
         OP_PCAP:   p2_ff <= pos_rd_ff;
         OP_DIFF: begin
            uses_ff <= 1'b1;
            for (int k = 0; k < 3; k++) begin
               a_ff[k] <= DIFF_W'(crd(p1_ff, k)) - DIFF_W'(crd(p0_ff, k));
               b_ff[k] <= DIFF_W'(crd(p2_ff, k)) - DIFF_W'(crd(p1_ff, k));
            end
         end
         OP_MUL: prod_ff <= prod_w;
         OP_CROSS: begin
            if (!cmd.step[0]) cr_ff <= prod_ff;
            else              acc_ff[cmd.step[2:1]] <= sat_w;
         end
         OP_TNEXT: t_ff <= t_ff + 1'b1;
         OP_ABS: begin
            for (int k = 0; k < 3; k++) u_ff[k] <= abs_w[k][62:0];
         end
         OP_MAX: begin
            if (u_ff[0] >= u_ff[1] && u_ff[0] >= u_ff[2]) mx_ff <= u_ff[0];
            else if (u_ff[1] >= u_ff[2])                mx_ff <= u_ff[1];
            else                                        mx_ff <= u_ff[2];
         end
         OP_NORM: begin
            if (stat.norm_hi) begin
               mx_ff <= mx_ff >> 1;
               for (int k = 0; k < 3; k++) u_ff[k] <= u_ff[k] >> 1;
            end else begin
               mx_ff <= mx_ff << 1;
               for (int k = 0; k < 3; k++) u_ff[k] <= u_ff[k] << 1;
            end
         end
         OP_SQ: s_ff <= ((cmd.step == '0) ? 64'd0 : s_ff) + 64'(sq_w);
         OP_RINIT: begin
            rem_ff  <= s_ff;
            root_ff <= '0;
            bit_ff  <= 64'd1 << 62;
         end
         OP_ROOT: begin
            if (rem_ff >= trial_w) begin
               rem_ff  <= rem_ff - trial_w;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         OP_DINIT: begin
            dnum_ff <= (46'(u_ff[cmd.comp][29:0]) << 14) + 46'(root_ff >> 1);
            dsr_ff  <= 46'(root_ff[31:0]) << (DIV_STEPS - 1);
            q_ff    <= '0;
         end
         OP_DIV: begin
            if (dnum_ff >= dsr_ff) begin
               dnum_ff <= dnum_ff - dsr_ff;
               q_ff    <= {q_ff[NORM_BITS-2:0], 1'b1};
            end else begin
               q_ff <= {q_ff[NORM_BITS-2:0], 1'b0};
            end
            dsr_ff <= dsr_ff >> 1;
         end
         OP_DSTORE: begin
            res_ff[cmd.comp] <= acc_ff[cmd.comp][63] ? -$signed(q_ff) : $signed(q_ff);
         end
         OP_EMIT: begin
            rsp_vertex_ff <= IDX_BITS'(vi_ff);
            rsp_nx_ff     <= emit_nrm[0 +: NORM_BITS];
            rsp_ny_ff     <= emit_nrm[NORM_BITS +: NORM_BITS];
            rsp_nz_ff     <= emit_nrm[2*NORM_BITS +: NORM_BITS];
            rsp_status_ff <= cmd.rstat;
         end
         default: begin
         end
      endcase
   end

   assign stat.nz_normal = (nrm_rd_ff != '0);
   assign stat.t_end     = (t_ff >= tcount_ff);
   assign stat.hit       = (tri_rd_ff[0 +: VIDX] == vi_ff) ||
                           (tri_rd_ff[VIDX +: VIDX] == vi_ff) ||
                           (tri_rd_ff[2*VIDX +: VIDX] == vi_ff);
   assign stat.no_uses   = !uses_ff;
   assign stat.acc_zero  = (acc_ff[0] == '0) && (acc_ff[1] == '0) && (acc_ff[2] == '0);
   assign stat.norm_hi   = (mx_ff[62:30] != '0);
   assign stat.norm_lo   = (mx_ff[62:29] == '0);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_vertex = rsp_vertex_ff;
   assign rsp_normal_x      = rsp_nx_ff;
   assign rsp_normal_y      = rsp_ny_ff;
   assign rsp_normal_z      = rsp_nz_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

FILE: src/vertex_normal_accumulator_core.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_core
// Area-weighted vertex normals over a mesh held in on-chip stores.
// ----------------------------------------------------------------------------
// A command transfers when start is high and busy is low. Clear, vertex write
// and triangle append keep busy low and give no result. A compute
// command holds busy until its single result appears: rsp_valid is high for
// exactly one cycle with the vertex, the Q1.14 normal and the status, and the
// receiver must take it then, since the block cannot hold a result back.
// A preset normal returns without a walk. Otherwise the triangle store is walked
// one entry at a time through its single read port; each triangle that uses
// the vertex takes three position reads and six products through one shared
// multiplier. An empty or zero sum then finishes with a zero normal. A nonzero
// sum goes through one-bit normalizing shifts, squaring, the bit-pair square
// root and the restoring divider for each of the three components.
// Stores need no clearing pass after reset.
module vertex_normal_accumulator_core
   import vna_pkg::*;
#(
   parameter int MAX_VERTICES  = DEF_MAX_VERTICES,
   parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES,
   parameter int COORD_BITS    = DEF_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_cmd,
   input  logic [IDX_BITS-1:0]          req_vertex_index,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_pos_z,
   input  logic signed [NORM_BITS-1:0]  req_preset_nx,
   input  logic signed [NORM_BITS-1:0]  req_preset_ny,
   input  logic signed [NORM_BITS-1:0]  req_preset_nz,
   input  logic [IDX_BITS-1:0]          req_corner_a,
   input  logic [IDX_BITS-1:0]          req_corner_b,
   input  logic [IDX_BITS-1:0]          req_corner_c,
   output logic                         rsp_valid,
   output logic [IDX_BITS-1:0]          rsp_result_vertex,
   output logic signed [NORM_BITS-1:0]  rsp_normal_x,
   output logic signed [NORM_BITS-1:0]  rsp_normal_y,
   output logic signed [NORM_BITS-1:0]  rsp_normal_z,
   output logic [1:0]                   rsp_status
);

`include "assert_macros.svh"

   vna_cmd_type  dp_cmd;
   vna_stat_type dp_stat;

   // The sequencer owns the step and component counts; the datapath owns stores, the walk index and math.
   vna_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .stat    (dp_stat),
      .cmd     (dp_cmd),
      .busy    (busy)
   );

   vna_dpath #(
      .MAX_VERTICES  (MAX_VERTICES),
      .MAX_TRIANGLES (MAX_TRIANGLES),
      .COORD_BITS    (COORD_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .stat              (dp_stat),
      .req_vertex_index  (req_vertex_index),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_preset_nx     (req_preset_nx),
      .req_preset_ny     (req_preset_ny),
      .req_preset_nz     (req_preset_nz),
      .req_corner_a      (req_corner_a),
      .req_corner_b      (req_corner_b),
      .req_corner_c      (req_corner_c),
      .rsp_valid         (rsp_valid),
      .rsp_result_vertex (rsp_result_vertex),
      .rsp_normal_x      (rsp_normal_x),
      .rsp_normal_y      (rsp_normal_y),
      .rsp_normal_z      (rsp_normal_z),
      .rsp_status        (rsp_status)
   );

   // A result is only raised as the compute command retires.
   `VNA_ASSERT_IMP(a_rsp_when_idle, rsp_valid, !busy, "result while still busy")
   // One compute command yields exactly one result strobe.
   `VNA_ASSERT_NXT(a_rsp_single, rsp_valid, !rsp_valid, "result strobe repeated")
   // Store commands complete in the cycle of their transfer.
   `VNA_ASSERT_NXT(a_store_cmd_quick, start && !busy && (req_cmd != CMD_COMPUTE), !busy,
                   "store command did not retire at once")
   // Degenerate and empty results carry a zero normal.
   `VNA_ASSERT_IMP(a_zero_normal,
                   rsp_valid && ((rsp_status == RS_DEGEN) || (rsp_status == RS_NO_TRI)),
                   (rsp_normal_x == '0) && (rsp_normal_y == '0) && (rsp_normal_z == '0),
                   "nonzero normal on empty or degenerate result")

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the vertex normal accumulator core.
// ----------------------------------------------------------------------------
// Commands are driven one transfer at a time through the start/busy handshake.
// A scoreboard keeps its own copy of the vertex, normal and triangle stores.
// It works out every compute result as soon as the command transfers, and it
// compares each strobed result, field by field, with the oldest one waiting.
// The stimulus has a directed part (extreme coordinates, presets, empty and
// degenerate sums, repeated corners). After that come random mesh episodes:
// clear (most of the time), write vertices, append triangles, compute.
// ----------------------------------------------------------------------------
module testbench;
   import vna_pkg::*;

   localparam int NUM_VERTICES  = DEF_MAX_VERTICES;
   localparam int NUM_TRIANGLES = DEF_MAX_TRIANGLES;
   localparam int RANDOM_ITEMS  = 270;
   // The limit covers a compute over a full store of matching triangles.
   localparam int QUIET_LIMIT   = 200000;

   typedef struct {
      logic [1:0]           cmd;
      logic [IDX_BITS-1:0]  vertex;
      logic [15:0]          pos [3];
      logic [15:0]          preset [3];
      logic [IDX_BITS-1:0]  corner [3];
   } mesh_cmd_type;

   typedef struct {
      logic [IDX_BITS-1:0]  vertex;
      logic [15:0]          normal [3];
      logic [1:0]           status;
   } normal_result_type;

   // Scoreboard: a mirror of the mesh stores plus the queue of normals that
   // are still on their way out of the block.
   class normal_scoreboard;
      logic signed [15:0]  positions [NUM_VERTICES][3];
      logic signed [15:0]  normals [NUM_VERTICES][3];
      logic [IDX_BITS-1:0] triangles [NUM_TRIANGLES][3];
      int                  triangle_count = 0;
      normal_result_type   pending_normals [$];
      int                  errors = 0;

      task report_mismatch(input string what);
         errors++;
         $display("[%0t] MISMATCH: %s", $time, what);
      endtask

      function longint clamp_add(input longint a, input longint b);
         longint s;
         longint lim;
         lim = longint'(1) <<< 62;
         s = a + b;
         if (s > lim) return lim;
         if (s < -lim) return -lim;
         return s;
      endfunction

      function longint unsigned floor_sqrt(input longint unsigned s);
         longint unsigned root;
         longint unsigned probe;
         root = 0;
         probe = longint'(1) << 62;
         while (probe > s) probe >>= 2;
         while (probe != 0) begin
            if (s >= root + probe) begin
               s -= root + probe;
               root = (root >> 1) + probe;
            end else begin
               root >>= 1;
            end
            probe >>= 2;
         end
         return root;
      endfunction

      // Scale the summed cross product to unit length in Q1.14.
      function void scale_to_unit(input longint sum [3], output logic [15:0] unit [3]);
         longint unsigned mag [3];
         longint unsigned peak;
         longint unsigned len;
         longint unsigned sq;
         longint q;
         peak = 0;
         sq = 0;
         for (int k = 0; k < 3; k++) begin
            mag[k] = (sum[k] < 0) ? longint'(-sum[k]) : longint'(sum[k]);
            if (mag[k] > peak) peak = mag[k];
         end
         while (peak >= (longint'(1) << 30)) begin
            peak >>= 1;
            for (int k = 0; k < 3; k++) mag[k] >>= 1;
         end
         while (peak < (longint'(1) << 29)) begin
            peak <<= 1;
            for (int k = 0; k < 3; k++) mag[k] <<= 1;
         end
         for (int k = 0; k < 3; k++) sq += mag[k] * mag[k];
         len = floor_sqrt(sq);
         for (int k = 0; k < 3; k++) begin
            q = longint'((mag[k] * 16384 + len / 2) / len);
            unit[k] = (sum[k] < 0) ? 16'(-q) : 16'(q);
         end
      endfunction

      // Called for every command at the edge where it transfers.
      function void note_command(input mesh_cmd_type c);
         normal_result_type r;
         longint         sum [3];
         longint         ea [3];
         longint         eb [3];
         int             uses;
         logic [IDX_BITS-1:0] v;
         v = c.vertex;
         case (c.cmd)
            CMD_CLEAR: triangle_count = 0;
            CMD_VERTEX: begin
               for (int k = 0; k < 3; k++) begin
                  positions[v][k] = c.pos[k];
                  normals[v][k] = c.preset[k];
               end
            end
            CMD_TRIANGLE: begin
               if (triangle_count < NUM_TRIANGLES) begin
                  for (int k = 0; k < 3; k++) triangles[triangle_count][k] = c.corner[k];
                  triangle_count++;
               end
            end
            default: begin
               r.vertex = v;
               if (normals[v][0] != 0 || normals[v][1] != 0 || normals[v][2] != 0) begin
                  for (int k = 0; k < 3; k++) r.normal[k] = normals[v][k];
                  r.status = RS_PRESET;
               end else begin
                  uses = 0;
                  for (int k = 0; k < 3; k++) sum[k] = 0;
                  for (int t = 0; t < triangle_count; t++) begin
                     if (triangles[t][0] == v || triangles[t][1] == v ||
                         triangles[t][2] == v) begin
                        for (int k = 0; k < 3; k++) begin
                           ea[k] = longint'(positions[triangles[t][1]][k]) -
                                   longint'(positions[triangles[t][0]][k]);
                           eb[k] = longint'(positions[triangles[t][2]][k]) -
                                   longint'(positions[triangles[t][1]][k]);
                        end
                        sum[0] = clamp_add(sum[0], ea[1] * eb[2] - ea[2] * eb[1]);
                        sum[1] = clamp_add(sum[1], ea[2] * eb[0] - ea[0] * eb[2]);
                        sum[2] = clamp_add(sum[2], ea[0] * eb[1] - ea[1] * eb[0]);
                        uses++;
                     end
                  end
                  for (int k = 0; k < 3; k++) r.normal[k] = '0;
                  if (uses == 0) r.status = RS_NO_TRI;
                  else if (sum[0] == 0 && sum[1] == 0 && sum[2] == 0) r.status = RS_DEGEN;
                  else begin
                     scale_to_unit(sum, r.normal);
                     r.status = RS_COMPUTED;
                  end
                  for (int k = 0; k < 3; k++) normals[v][k] = r.normal[k];
               end
               pending_normals.push_back(r);
            end
         endcase
      endfunction

      task check_result(input normal_result_type got);
         normal_result_type want;
         if (pending_normals.size() == 0) begin
            report_mismatch($sformatf("result for vertex %0d with none expected",
                                      got.vertex));
         end else begin
            want = pending_normals.pop_front();
            if (got.vertex !== want.vertex)
               report_mismatch($sformatf("vertex got %0d want %0d", got.vertex, want.vertex));
            for (int k = 0; k < 3; k++)
               if (got.normal[k] !== want.normal[k])
                  report_mismatch($sformatf("vertex %0d normal[%0d] got %h want %h",
                                            want.vertex, k, got.normal[k], want.normal[k]));
            if (got.status !== want.status)
               report_mismatch($sformatf("vertex %0d status got %0d want %0d",
                                         want.vertex, got.status, want.status));
         end
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_cmd;
   logic [IDX_BITS-1:0] req_vertex_index;
   logic signed [15:0]  req_pos_x, req_pos_y, req_pos_z;
   logic signed [15:0]  req_preset_nx, req_preset_ny, req_preset_nz;
   logic [IDX_BITS-1:0] req_corner_a, req_corner_b, req_corner_c;
   logic                rsp_valid;
   logic [IDX_BITS-1:0] rsp_result_vertex;
   logic signed [15:0]  rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic [1:0]          rsp_status;

   normal_scoreboard normal_sb = new();

   // Vertices whose position has been written; only these are ever named by
   // a compute or a triangle corner, since unwritten entries are undefined.
   bit                  written [NUM_VERTICES];
   int                  written_list [$];
   int                  idle_pct = 0;
   int                  random_sent = 0;
   int                  quiet_cycles = 0;

   vertex_normal_accumulator_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_vertex_index  (req_vertex_index),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_preset_nx     (req_preset_nx),
      .req_preset_ny     (req_preset_ny),
      .req_preset_nz     (req_preset_nz),
      .req_corner_a      (req_corner_a),
      .req_corner_b      (req_corner_b),
      .req_corner_c      (req_corner_c),
      .rsp_valid         (rsp_valid),
      .rsp_result_vertex (rsp_result_vertex),
      .rsp_normal_x      (rsp_normal_x),
      .rsp_normal_y      (rsp_normal_y),
      .rsp_normal_z      (rsp_normal_z),
      .rsp_status        (rsp_status)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Results cannot be held off, so every strobe is checked at its edge.
   always @(posedge clock) begin
      normal_result_type got;
      if (!reset && rsp_valid) begin
         got.vertex = rsp_result_vertex;
         got.normal[0] = rsp_normal_x;
         got.normal[1] = rsp_normal_y;
         got.normal[2] = rsp_normal_z;
         got.status = rsp_status;
         normal_sb.check_result(got);
      end
   end

   // Watchdog: ends the run if nothing transfers for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Drives one command and waits for its transfer. With settle set, start
   // drops and the sender waits until every expected normal has come back;
   // otherwise the sender idles at random according to idle_pct.
   task automatic issue(input mesh_cmd_type c, input bit settle = 1'b0);
      req_cmd <= c.cmd;
      req_vertex_index <= c.vertex;
      req_pos_x <= c.pos[0];
      req_pos_y <= c.pos[1];
      req_pos_z <= c.pos[2];
      req_preset_nx <= c.preset[0];
      req_preset_ny <= c.preset[1];
      req_preset_nz <= c.preset[2];
      req_corner_a <= c.corner[0];
      req_corner_b <= c.corner[1];
      req_corner_c <= c.corner[2];
      start <= 1'b1;
      do @(posedge clock); while (busy);
      normal_sb.note_command(c);
      if (c.cmd == CMD_VERTEX && !written[c.vertex]) begin
         written[c.vertex] = 1'b1;
         written_list.push_back(c.vertex);
      end
      if (settle) begin
         start <= 1'b0;
         while (normal_sb.pending_normals.size() != 0) @(posedge clock);
      end else if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic mesh_cmd_type blank_cmd(input logic [1:0] cmd);
      mesh_cmd_type c;
      c.cmd = cmd;
      c.vertex = IDX_BITS'($urandom);
      for (int k = 0; k < 3; k++) begin
         c.pos[k] = 16'($urandom);
         c.preset[k] = 16'($urandom);
         c.corner[k] = IDX_BITS'($urandom);
      end
      return c;
   endfunction

   task automatic put_vertex(input int idx, input int x, input int y, input int z,
                             input int nx = 0, input int ny = 0, input int nz = 0);
      mesh_cmd_type c;
      c = blank_cmd(CMD_VERTEX);
      c.vertex = IDX_BITS'(idx);
      c.pos[0] = 16'(x);
      c.pos[1] = 16'(y);
      c.pos[2] = 16'(z);
      c.preset[0] = 16'(nx);
      c.preset[1] = 16'(ny);
      c.preset[2] = 16'(nz);
      issue(c);
   endtask

   task automatic put_triangle(input int a, input int b, input int c3);
      mesh_cmd_type c;
      c = blank_cmd(CMD_TRIANGLE);
      c.corner[0] = IDX_BITS'(a);
      c.corner[1] = IDX_BITS'(b);
      c.corner[2] = IDX_BITS'(c3);
      issue(c);
   endtask

   task automatic ask_normal(input int idx, input bit settle = 1'b0);
      mesh_cmd_type c;
      c = blank_cmd(CMD_COMPUTE);
      c.vertex = IDX_BITS'(idx);
      issue(c, settle);
   endtask

   task automatic clear_mesh();
      issue(blank_cmd(CMD_CLEAR));
   endtask

   function automatic logic [15:0] random_coord();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return ($urandom_range(1)) ? 16'h7fff : 16'h8000;
         default: return 16'($urandom_range(0, 1023) - 512);
      endcase
   endfunction

   function automatic int pick_written(input int episode [$]);
      if (episode.size() != 0 && $urandom_range(99) < 85)
         return episode[$urandom_range(episode.size() - 1)];
      return written_list[$urandom_range(written_list.size() - 1)];
   endfunction

   // One well-formed episode: a clear (most of the time), load vertices, append
   // triangles, then ask for normals. A little noise is mixed in between.
   task automatic mesh_episode();
      int        episode [$];
      int        idx;
      int        a, b, c3;
      mesh_cmd_type c;
      if ($urandom_range(99) < 85) begin
         clear_mesh();
         random_sent++;
      end
      repeat ($urandom_range(3, 8)) begin
         idx = $urandom_range(0, NUM_VERTICES - 1);
         if ($urandom_range(99) < 85) put_vertex(idx, random_coord(), random_coord(),
                                                 random_coord());
         else put_vertex(idx, random_coord(), random_coord(), random_coord(),
                         16'($urandom), 16'($urandom), 16'($urandom));
         episode.push_back(idx);
         random_sent++;
      end
      repeat ($urandom_range(1, 6)) begin
         a = pick_written(episode);
         b = pick_written(episode);
         c3 = ($urandom_range(99) < 10) ? a : pick_written(episode);
         put_triangle(a, b, c3);
         random_sent++;
      end
      repeat ($urandom_range(1, 4)) begin
         if ($urandom_range(99) < 10) begin
            // Noise: a stray write or a compute of any loaded vertex.
            if ($urandom_range(1)) begin
               c = blank_cmd(CMD_VERTEX);
               issue(c);
            end else begin
               ask_normal(written_list[$urandom_range(written_list.size() - 1)]);
            end
            random_sent++;
         end
         ask_normal(pick_written(episode));
         random_sent++;
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_cmd = CMD_CLEAR;
      req_vertex_index = '0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      req_preset_nx = '0;
      req_preset_ny = '0;
      req_preset_nz = '0;
      req_corner_a = '0;
      req_corner_b = '0;
      req_corner_c = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: extremes on every field, then each special case.
      put_vertex(0, 0, 0, 0);
      put_vertex(1023, 16'h7fff, 16'h8000, 0);
      put_vertex(341, 0, 16'h7fff, 16'h8000);
      put_vertex(682, 16'h8000, 16'h8000, 16'h7fff);
      // A nonzero preset comes back as stored, even outside the unit range.
      put_vertex(5, 100, 200, 300, 16384, 16'hc000, 16'h7fff);
      ask_normal(5);
      // No triangles loaded yet.
      ask_normal(0);
      put_triangle(0, 1023, 341);
      put_triangle(682, 341, 0);
      // Repeated corners: the vertex counts once, and the cross product is zero.
      put_triangle(1023, 1023, 0);
      ask_normal(341);
      ask_normal(341);
      ask_normal(1023);
      // Coincident positions give a zero sum.
      put_vertex(10, 100, 100, 100);
      put_vertex(11, 100, 100, 100);
      put_vertex(12, 100, 100, 100);
      put_triangle(10, 11, 12);
      ask_normal(10);
      ask_normal(682, 1'b1);
      // Clearing drops the triangles but keeps the vertices.
      clear_mesh();
      put_vertex(682, 16'h8000, 16'h8000, 16'h7fff);
      ask_normal(682, 1'b1);

      // Random episodes: the sender idles a little, then a lot, then not at all.
      while (random_sent < RANDOM_ITEMS) begin
         idle_pct = (random_sent < RANDOM_ITEMS / 3) ? 7 :
                    (random_sent < 2 * RANDOM_ITEMS / 3) ? 45 : 0;
         mesh_episode();
         if ($urandom_range(99) < 40) begin
            start <= 1'b0;
            while (normal_sb.pending_normals.size() != 0) @(posedge clock);
         end
      end
      start <= 1'b0;

      while (normal_sb.pending_normals.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (normal_sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: vertex_normal_accumulator_core.f
+incdir+src
src/vna_pkg.sv
src/vna_ctrl.sv
src/vna_dpath.sv
src/vertex_normal_accumulator_core.sv
dv/testbench.sv
